>>> rtl/rpdd_pkg.sv
// shared types and constants for the rotary pulse dial decoder
package rpdd_pkg;

    localparam int THR_BITS       = 10;
    localparam int TICKS_BITS     = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int DIGIT_BITS     = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_THRESHOLD     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TICKS      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_PULSE_TICKS     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_PULSE_TICKS     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIGIT_TIMEOUT_TICKS = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HANG_UP_TICKS       = 3'd5;

    // reset values of the configuration registers
    localparam logic [THR_BITS-1:0]   RST_LEVEL_THRESHOLD     = 10'd310;
    localparam logic [TICKS_BITS-1:0] RST_DEBOUNCE_TICKS      = 16'd20;
    localparam logic [TICKS_BITS-1:0] RST_MIN_PULSE_TICKS     = 16'd40;
    localparam logic [TICKS_BITS-1:0] RST_MAX_PULSE_TICKS     = 16'd100;
    localparam logic [TICKS_BITS-1:0] RST_DIGIT_TIMEOUT_TICKS = 16'd300;
    localparam logic [TICKS_BITS-1:0] RST_HANG_UP_TICKS       = 16'd300;

    typedef enum logic [1:0] {
        ST_ON_HOOK,
        ST_AWAIT,
        ST_DIALING,
        ST_CAPTURED
    } dial_state_t;

    typedef struct packed {
        logic [THR_BITS-1:0]   level_threshold;
        logic [TICKS_BITS-1:0] debounce_ticks;
        logic [TICKS_BITS-1:0] min_pulse_ticks;
        logic [TICKS_BITS-1:0] max_pulse_ticks;
        logic [TICKS_BITS-1:0] digit_timeout_ticks;
        logic [TICKS_BITS-1:0] hang_up_ticks;
    } rpdd_cfg_t;

    typedef struct packed {
        dial_state_t           phone_state;
        logic                  line_high;
        logic                  dial_tone_on;
        logic                  digit_ready;
        logic [DIGIT_BITS-1:0] digit;
    } rpdd_result_t;

endpackage

>>> rtl/rotary_pulse_dial_decoder_unit.sv
// Rotary pulse dial decoder: one line sample per tick in, one status item out per sample.
// An item enters the input register, is decoded in a single pass against the stored line
// state and leaves through the result register, so the block takes one item every cycle
// while the result register is free or being emptied. That rate is set by the path from
// the input register through the decoder compares to the state and result registers.
// Configuration registers take effect on the next item and come up with their reset
// values; there is no clearing pass after reset.
module rotary_pulse_dial_decoder_unit #(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [SAMPLE_BITS-1:0]              line_sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          phone_state,
    output logic                                line_high,
    output logic                                dial_tone_on,
    output logic                                digit_ready,
    output logic [rpdd_pkg::DIGIT_BITS-1:0]     digit,
    input  logic                                cfg_write,
    input  logic [rpdd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rpdd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import rpdd_pkg::*;

    rpdd_cfg_t              cfg_reg;
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_valid_reg;
    rpdd_result_t           out_reg;
    rpdd_result_t           result;
    logic                   advance;

    // decode when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_threshold     <= RST_LEVEL_THRESHOLD;
            cfg_reg.debounce_ticks      <= RST_DEBOUNCE_TICKS;
            cfg_reg.min_pulse_ticks     <= RST_MIN_PULSE_TICKS;
            cfg_reg.max_pulse_ticks     <= RST_MAX_PULSE_TICKS;
            cfg_reg.digit_timeout_ticks <= RST_DIGIT_TIMEOUT_TICKS;
            cfg_reg.hang_up_ticks       <= RST_HANG_UP_TICKS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LEVEL_THRESHOLD:     cfg_reg.level_threshold <= cfg_data[THR_BITS-1:0];
                REG_DEBOUNCE_TICKS:      cfg_reg.debounce_ticks <= cfg_data;
                REG_MIN_PULSE_TICKS:     cfg_reg.min_pulse_ticks <= cfg_data;
                REG_MAX_PULSE_TICKS:     cfg_reg.max_pulse_ticks <= cfg_data;
                REG_DIGIT_TIMEOUT_TICKS: cfg_reg.digit_timeout_ticks <= cfg_data;
                REG_HANG_UP_TICKS:       cfg_reg.hang_up_ticks <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            sample_reg <= line_sample;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    rpdd_engine #(
        .TIME_BITS   (TIME_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (sample_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign out_valid    = out_valid_reg;
    assign phone_state  = out_reg.phone_state;
    assign line_high    = out_reg.line_high;
    assign dial_tone_on = out_reg.dial_tone_on;
    assign digit_ready  = out_reg.digit_ready;
    assign digit        = out_reg.digit;

`ifndef NO_ASSERTIONS
    // a captured digit always lands in the captured state
    a_ready_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && digit_ready |-> phone_state == ST_CAPTURED)
        else $error("digit ready outside captured state");

    // a captured digit never carries a zero count
    a_ready_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && digit_ready |-> digit != '0)
        else $error("digit ready with zero pulse count");

    // capture only happens from dialing, never with dial tone
    a_ready_tone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && digit_ready |-> !dial_tone_on)
        else $error("digit ready while dial tone on");

    // the input side only holds off while a decoded item is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with result register free");
`endif

endmodule

>>> rtl/rpdd_engine.sv
// per-item decode: level tracking, debounce, hang-up and dial state machine
module rpdd_engine #(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [SAMPLE_BITS-1:0]   sample,
    input  rpdd_pkg::rpdd_cfg_t      cfg,
    output rpdd_pkg::rpdd_result_t   result
);
    import rpdd_pkg::*;

    localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    logic [TIME_BITS-1:0]  tick_reg, tick_next;
    logic                  raw_reg, raw_next;
    logic                  deb_reg, deb_next;
    logic                  taken_reg, taken_next;
    logic [TIME_BITS-1:0]  rise_reg, rise_next;
    logic [TIME_BITS-1:0]  fall_reg, fall_next;
    dial_state_t           state_reg, state_next;
    logic [DIGIT_BITS-1:0] count_reg, count_next;

    logic [CMP_BITS-1:0]   sample_ext;
    logic [CMP_BITS-1:0]   thr_ext;
    logic [TIME_BITS-1:0]  since_rise;
    logic [TIME_BITS-1:0]  since_fall;
    logic [TIME_BITS-1:0]  pulse_width;
    logic                  hang_up;
    dial_state_t           acted;
    logic                  pulse_ok;
    logic                  ready;

    assign sample_ext = CMP_BITS'(sample);
    assign thr_ext    = CMP_BITS'(cfg.level_threshold);

    // raw edge stamps, debounce, hang-up and pulse width check
    always_comb
    begin
        raw_next  = raw_reg;
        rise_next = rise_reg;
        fall_next = fall_reg;
        if (sample_ext > thr_ext && !raw_reg)
        begin
            raw_next  = 1'b1;
            rise_next = tick_reg;
        end
        if (sample_ext < thr_ext && raw_reg)
        begin
            raw_next  = 1'b0;
            fall_next = tick_reg;
        end
        since_rise  = tick_reg - rise_next;
        since_fall  = tick_reg - fall_next;
        pulse_width = fall_next - rise_next;
        deb_next = deb_reg;
        if (raw_next && since_rise > TIME_BITS'(cfg.debounce_ticks))
        begin
            deb_next = 1'b1;
        end
        if (!raw_next && since_fall > TIME_BITS'(cfg.debounce_ticks))
        begin
            deb_next = 1'b0;
        end
        hang_up  = deb_next && since_rise > TIME_BITS'(cfg.hang_up_ticks);
        acted    = hang_up ? ST_ON_HOOK : state_reg;
        pulse_ok = pulse_width >= TIME_BITS'(cfg.min_pulse_ticks)
                && pulse_width <= TIME_BITS'(cfg.max_pulse_ticks);
    end

    // pulse counting and capture flag
    always_comb
    begin
        taken_next = taken_reg;
        count_next = count_reg;
        ready      = 1'b0;
        unique case (acted)
            ST_AWAIT:
            begin
                count_next = '0;
            end
            ST_DIALING:
            begin
                if (deb_next)
                begin
                    taken_next = 1'b0;
                end
                if (!taken_next && !deb_next && pulse_ok)
                begin
                    taken_next = 1'b1;
                    count_next = count_reg + DIGIT_BITS'(1);
                end
                ready = since_fall >= TIME_BITS'(cfg.digit_timeout_ticks)
                     && count_next != '0;
            end
            ST_ON_HOOK, ST_CAPTURED:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = acted;
        unique case (acted)
            ST_ON_HOOK:
            begin
                if (!deb_next)
                begin
                    state_next = ST_AWAIT;
                end
            end
            ST_AWAIT:
            begin
                if (deb_next)
                begin
                    state_next = ST_DIALING;
                end
            end
            ST_DIALING:
            begin
                if (ready)
                begin
                    state_next = ST_CAPTURED;
                end
            end
            ST_CAPTURED:
            begin
            end
        endcase
    end

    assign tick_next = tick_reg + TIME_BITS'(1);

    // result of this item
    always_comb
    begin
        result.phone_state  = state_next;
        result.line_high    = deb_next;
        result.dial_tone_on = (acted == ST_ON_HOOK) || (acted == ST_AWAIT);
        result.digit_ready  = ready;
        result.digit        = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            raw_reg   <= 1'b0;
            deb_reg   <= 1'b0;
            taken_reg <= 1'b0;
            rise_reg  <= '0;
            fall_reg  <= '0;
            state_reg <= ST_ON_HOOK;
            count_reg <= '0;
        end
        else if (step)
        begin
            tick_reg  <= tick_next;
            raw_reg   <= raw_next;
            deb_reg   <= deb_next;
            taken_reg <= taken_next;
            rise_reg  <= rise_next;
            fall_reg  <= fall_next;
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> test/dial_decode_checker.sv
`timescale 1ns / 1ps
// checker that predicts the dial decoder status items and compares them with the block
module dial_decode_checker #(
    parameter int TIME_BITS   = 32,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [SAMPLE_BITS-1:0]              line_sample,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [1:0]                          phone_state,
    input  logic                                line_high,
    input  logic                                dial_tone_on,
    input  logic                                digit_ready,
    input  logic [rpdd_pkg::DIGIT_BITS-1:0]     digit,
    input  logic                                cfg_write,
    input  logic [rpdd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rpdd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                  fail_count,
    output int                                  pending
);
    import rpdd_pkg::*;

    rpdd_cfg_t             cfg;
    logic [TIME_BITS-1:0]  tick_now;
    logic [TIME_BITS-1:0]  rose_at;
    logic [TIME_BITS-1:0]  fell_at;
    logic                  raw_up;
    logic                  settled_up;
    logic                  pulse_counted;
    dial_state_t           dial_mode;
    logic [DIGIT_BITS-1:0] pulse_total;
    rpdd_result_t          expected_status[$];
    int                    mismatches = 0;

    assign fail_count = mismatches;

    task automatic decode_tick(input logic [SAMPLE_BITS-1:0] s, output rpdd_result_t r);
        dial_state_t          acted;
        logic                 ready;
        logic [TIME_BITS-1:0] t;
        logic [TIME_BITS-1:0] width;
        t = tick_now;
        ready = 1'b0;
        if (s > cfg.level_threshold && !raw_up) begin
            rose_at = t;
            raw_up = 1'b1;
        end
        if (s < cfg.level_threshold && raw_up) begin
            fell_at = t;
            raw_up = 1'b0;
        end
        if (raw_up && (t - rose_at) > cfg.debounce_ticks)
            settled_up = 1'b1;
        if (!raw_up && (t - fell_at) > cfg.debounce_ticks)
            settled_up = 1'b0;
        // a long high is the receiver going back on hook
        if (settled_up && (t - rose_at) > cfg.hang_up_ticks)
            dial_mode = ST_ON_HOOK;
        acted = dial_mode;
        case (acted)
            ST_ON_HOOK:
            begin
                if (!settled_up)
                    dial_mode = ST_AWAIT;
            end
            ST_AWAIT:
            begin
                pulse_total = '0;
                if (settled_up)
                    dial_mode = ST_DIALING;
            end
            ST_DIALING:
            begin
                if (settled_up)
                    pulse_counted = 1'b0;
                if (!pulse_counted && !settled_up) begin
                    width = fell_at - rose_at;
                    if (width >= cfg.min_pulse_ticks && width <= cfg.max_pulse_ticks) begin
                        pulse_counted = 1'b1;
                        pulse_total = pulse_total + 1'b1;
                    end
                end
                // a wrapped count of zero never ends a digit
                if ((t - fell_at) >= cfg.digit_timeout_ticks && pulse_total != 0) begin
                    dial_mode = ST_CAPTURED;
                    ready = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        tick_now = tick_now + 1'b1;
        r.phone_state  = dial_mode;
        r.line_high    = settled_up;
        r.dial_tone_on = (acted == ST_ON_HOOK || acted == ST_AWAIT);
        r.digit_ready  = ready;
        r.digit        = pulse_total;
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        rpdd_result_t want;
        rpdd_result_t fresh;
        if (!rst_n) begin
            cfg.level_threshold     = RST_LEVEL_THRESHOLD;
            cfg.debounce_ticks      = RST_DEBOUNCE_TICKS;
            cfg.min_pulse_ticks     = RST_MIN_PULSE_TICKS;
            cfg.max_pulse_ticks     = RST_MAX_PULSE_TICKS;
            cfg.digit_timeout_ticks = RST_DIGIT_TIMEOUT_TICKS;
            cfg.hang_up_ticks       = RST_HANG_UP_TICKS;
            tick_now      = '0;
            rose_at       = '0;
            fell_at       = '0;
            raw_up        = 1'b0;
            settled_up    = 1'b0;
            pulse_counted = 1'b0;
            dial_mode     = ST_ON_HOOK;
            pulse_total   = '0;
            expected_status.delete();
            pending <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_status.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual state %0d line %0d",
                             $time, phone_state, line_high);
                    mismatches++;
                end
                else begin
                    want = expected_status.pop_front();
                    check_field("phone_state", want.phone_state, phone_state);
                    check_field("line_high", want.line_high, line_high);
                    check_field("dial_tone_on", want.dial_tone_on, dial_tone_on);
                    check_field("digit_ready", want.digit_ready, digit_ready);
                    check_field("digit", want.digit, digit);
                end
            end
            if (in_valid && !in_stall) begin
                decode_tick(line_sample, fresh);
                expected_status.push_back(fresh);
            end
            // a register write counts from the next item on
            if (cfg_write) begin
                case (cfg_index)
                    REG_LEVEL_THRESHOLD:     cfg.level_threshold     = cfg_data[THR_BITS-1:0];
                    REG_DEBOUNCE_TICKS:      cfg.debounce_ticks      = cfg_data;
                    REG_MIN_PULSE_TICKS:     cfg.min_pulse_ticks     = cfg_data;
                    REG_MAX_PULSE_TICKS:     cfg.max_pulse_ticks     = cfg_data;
                    REG_DIGIT_TIMEOUT_TICKS: cfg.digit_timeout_ticks = cfg_data;
                    REG_HANG_UP_TICKS:       cfg.hang_up_ticks       = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            pending <= expected_status.size();
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, dial stimulus and verdict for the rotary pulse dial decoder
module tb_top;
    import rpdd_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 150;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic [9:0]                line_sample = '0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic [1:0]                phone_state;
    logic                      line_high;
    logic                      dial_tone_on;
    logic                      digit_ready;
    logic [DIGIT_BITS-1:0]     digit;
    logic                      cfg_write   = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = REG_LEVEL_THRESHOLD;
    logic [CFG_DATA_BITS-1:0]  cfg_data    = '0;
    int                        fail_count;
    int                        pending;

    // our copy of the settings, used only to shape the stimulus
    int thr    = int'(RST_LEVEL_THRESHOLD);
    int deb_t  = int'(RST_DEBOUNCE_TICKS);
    int min_t  = int'(RST_MIN_PULSE_TICKS);
    int max_t  = int'(RST_MAX_PULSE_TICKS);
    int tmo_t  = int'(RST_DIGIT_TIMEOUT_TICKS);
    int hang_t = int'(RST_HANG_UP_TICKS);

    int sent_count  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int stall_mode  = 0;
    bit gaps_on     = 1'b1;
    int corner_samples [12] = '{0, 1023, 310, 311, 309, 'h155, 'h2AA, 1, 1022, 'h200, 'h1FF, 0};

    always #5 clk = ~clk;

    rotary_pulse_dial_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .line_sample  (line_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .phone_state  (phone_state),
        .line_high    (line_high),
        .dial_tone_on (dial_tone_on),
        .digit_ready  (digit_ready),
        .digit        (digit),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    dial_decode_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .line_sample  (line_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .phone_state  (phone_state),
        .line_high    (line_high),
        .dial_tone_on (dial_tone_on),
        .digit_ready  (digit_ready),
        .digit        (digit),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // receiver: stretches of no stall, light stall and heavy stall
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send(input int s);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        line_sample <= 10'(s);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_count++;
    endtask

    function automatic int above_thr();
        if (thr >= 1023)
            return 1023;
        return $urandom_range(thr + 1, 1023);
    endfunction

    function automatic int below_thr();
        if (thr <= 0)
            return 0;
        return $urandom_range(0, thr - 1);
    endfunction

    task automatic hold_line(input bit up, input int n);
        repeat (n) send(up ? above_thr() : below_thr());
    endtask

    task automatic noise(input int n);
        repeat (n) send(($urandom_range(0, 7) == 0) ? thr : $urandom_range(0, 1023));
    endtask

    // stop sending until every expected item is back, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(val);
        @(posedge clk);
    endtask

    task automatic load_config(input int t, input int d, input int mn, input int mx,
                               input int to, input int hu);
        drain();
        // upper data bits of the threshold write are junk the block must drop
        write_reg(REG_LEVEL_THRESHOLD, (t & 1023) | ($urandom_range(0, 63) << 10));
        write_reg(REG_DEBOUNCE_TICKS, d);
        write_reg(REG_MIN_PULSE_TICKS, mn);
        write_reg(REG_MAX_PULSE_TICKS, mx);
        write_reg(REG_DIGIT_TIMEOUT_TICKS, to);
        write_reg(REG_HANG_UP_TICKS, hu);
        cfg_write <= 1'b0;
        thr    = t & 1023;
        deb_t  = d;
        min_t  = mn;
        max_t  = mx;
        tmo_t  = to;
        hang_t = hu;
        gaps_on = ($urandom_range(0, 3) != 0);
    endtask

    // hang up, lift, dial one digit, wait for capture
    task automatic dial_call();
        int lo_w;
        int hi_w;
        lo_w = (min_t > deb_t + 2) ? min_t : deb_t + 2;
        hi_w = (max_t < lo_w + 8) ? max_t : lo_w + 8;
        if (hi_w < lo_w)
            hi_w = lo_w + 3;
        hold_line(1, ((hang_t > deb_t) ? hang_t : deb_t) + $urandom_range(2, 5));
        hold_line(0, deb_t + $urandom_range(2, 6));
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(0, 5) == 0)
                hold_line(1, $urandom_range(1, hi_w + 4));
            else
                hold_line(1, $urandom_range(lo_w, hi_w));
            hold_line(0, deb_t + $urandom_range(2, 5));
        end
        hold_line(0, tmo_t + $urandom_range(1, 6));
        // pulses after capture are ignored until hang-up
        if ($urandom_range(0, 2) == 0) begin
            hold_line(1, lo_w);
            hold_line(0, deb_t + 2);
        end
    endtask

    initial begin
        int mn;
        int mx;
        int d;
        int target;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes and samples on and around the default threshold
        foreach (corner_samples[i])
            send(corner_samples[i]);

        // pulse count wraps past 255 without capturing, then one more pulse captures
        load_config(310, 0, 2, 2, 8, 40);
        hold_line(0, 4);
        repeat (256) begin
            hold_line(1, 2);
            hold_line(0, 2);
        end
        hold_line(0, 12);
        hold_line(1, 2);
        hold_line(0, 14);
        hold_line(1, 45);

        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target) begin
            d  = $urandom_range(0, 3);
            mn = $urandom_range(1, 6);
            mx = mn + $urandom_range(0, 6);
            case ($urandom_range(0, 9))
                0: load_config($urandom_range(0, 1023), 0, 0, 0, 0, 0);
                1: load_config($urandom_range(0, 1023), 65535, 65535, 65535, 65535, 65535);
                2: load_config($urandom_range(0, 1) ? 1023 : 0, d, mn, mx,
                               mx + $urandom_range(2, 20), mx + d + $urandom_range(2, 30));
                3: load_config($urandom_range(1, 1022), d, mn + 4, mn + 3 - $urandom_range(0, 3),
                               $urandom_range(6, 20), $urandom_range(12, 40));
                4: load_config($urandom_range(1, 1022), d, 0, 65535,
                               $urandom_range(12, 30), $urandom_range(14, 40));
                default: load_config($urandom_range(1, 1022), d, mn, mx,
                                     mx + $urandom_range(2, 20),
                                     mx + d + $urandom_range(2, 30));
            endcase
            if (hang_t < 1000) begin
                repeat ($urandom_range(2, 4)) begin
                    if (sent_count < target) begin
                        dial_call();
                        if ($urandom_range(0, 2) == 0)
                            noise($urandom_range(5, 25));
                    end
                end
            end
            else begin
                noise($urandom_range(20, 60));
                hold_line(1, $urandom_range(5, 20));
                hold_line(0, $urandom_range(5, 20));
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rpdd_pkg.sv
rtl/rpdd_engine.sv
rtl/rotary_pulse_dial_decoder_unit.sv
test/dial_decode_checker.sv
test/tb_top.sv
